// ===== design/wsd_pkg.sv =====
// Package with shared types, constants and a conversion function for the WAVE stream decoder.
`default_nettype none
package wsd_pkg;
    localparam int MaxChannels = 8;
    localparam int FracBits    = 23;
    localparam int ChanW       = $clog2(MaxChannels + 1);
    localparam int SumW        = FracBits + 2 + ChanW;

    localparam logic [31:0] TagRiff = 32'h4646_4952;
    localparam logic [31:0] TagWave = 32'h4556_4157;
    localparam logic [31:0] TagFmt  = 32'h2074_6D66;
    localparam logic [31:0] TagData = 32'h6174_6164;

    localparam logic [3:0] StOk        = 4'd0;
    localparam logic [3:0] StShort     = 4'd1;
    localparam logic [3:0] StNotWave   = 4'd2;
    localparam logic [3:0] StNoData    = 4'd3;
    localparam logic [3:0] StZeroChan  = 4'd4;
    localparam logic [3:0] StZeroRate  = 4'd5;
    localparam logic [3:0] StBadFormat = 4'd6;
    localparam logic [3:0] StNoAudio   = 4'd7;
    localparam logic [3:0] StManyChan  = 4'd8;
    localparam logic [3:0] StFmtLate   = 4'd9;

    // Work handed from the parser to the mixer.
    typedef struct packed {
        logic                   smp;     // one complete channel sample
        logic                   is_float;
        logic [31:0]            word;
        logic                   last;    // frame closes with this sample
        logic                   eof;
        logic [3:0]             status;
        logic [31:0]            rate;
        logic [15:0]            chans;
        logic [15:0]            bits;
        logic                   fmt_float;
    } wsd_job_t;

    // Converts a raw sample word to signed fixed point.
    function automatic logic signed [FracBits+1:0] to_fixed(input logic [31:0] w,
                                                            input logic is_float);
        logic [7:0]  ex;
        logic [23:0] sig;
        logic [63:0] mag;
        int          sh;
        logic signed [FracBits+1:0] r;
        ex  = w[30:23];
        sig = {1'b1, w[22:0]};
        sh  = int'(ex) - 150 + FracBits;
        mag = '0;
        r   = '0;
        if (!is_float) begin
            r = (FracBits + 2)'($signed(w[31:16])) <<< (FracBits - 15);
        end else if (ex == 8'd0 || (ex == 8'hFF && w[22:0] != 23'd0)) begin
            r = '0;
        end else if (ex >= 8'd127) begin
            r = w[31] ? -((FracBits + 2)'(1) <<< FracBits)
                      : ((FracBits + 2)'(1) <<< FracBits) - 1;
        end else begin
            if (sh >= 0) mag = 64'(sig) << sh;
            else if (-sh >= 32) mag = '0;
            else mag = 64'(sig) >> (-sh);
            r = w[31] ? -$signed((FracBits + 2)'(mag)) : $signed((FracBits + 2)'(mag));
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/wsd_parser.sv =====
// Front part: walks the RIFF chunks byte by byte and hands samples and summaries to the queue.
`default_nettype none
module wsd_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_eof,
    output logic                   job_valid,
    output wsd_pkg::wsd_job_t      job,
    input  wire logic              job_ready
);
    typedef enum logic [2:0] {PH_RIFF, PH_HDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_HALT}
        phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] off_reg, off_next, tag_reg, tag_next, left_reg, left_next;
    logic [31:0] rate_reg, rate_next, id_reg, id_next;
    logic [15:0] fmt_reg, fmt_next, chan_reg, chan_next, bits_reg, bits_next;
    logic [1:0]  seen_reg, seen_next;
    logic        pad_reg, pad_next, four_reg, four_next;
    logic [1:0]  bis_reg, bis_next;
    logic [wsd_pkg::ChanW-1:0] ci_reg, ci_next;
    logic [31:0] frames_reg, frames_next;
    logic [3:0]  fault_reg, fault_next;
    logic [2:0]  hpos_reg, hpos_next;
    logic [4:0]  bpos_reg, bpos_next;
    logic        fire, body, smp, last;
    logic [3:0]  st;

    assign in_ready = job_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        tag_next = {in_byte, tag_reg[31:8]};
        phase_next = phase_reg; off_next = off_reg; left_next = left_reg;
        rate_next = rate_reg; id_next = id_reg; fmt_next = fmt_reg; chan_next = chan_reg;
        bits_next = bits_reg; seen_next = seen_reg; pad_next = pad_reg; four_next = four_reg;
        bis_next = bis_reg; ci_next = ci_reg; frames_next = frames_reg;
        fault_next = fault_reg; hpos_next = hpos_reg; bpos_next = bpos_reg;
        body = 1'b0; smp = 1'b0; last = 1'b0;
        unique case (phase_reg)
            PH_RIFF: begin
                if (off_reg == 32'd3 && tag_next != wsd_pkg::TagRiff) begin
                    fault_next = wsd_pkg::StNotWave; phase_next = PH_HALT;
                end else if (off_reg == 32'd11) begin
                    if (tag_next != wsd_pkg::TagWave) begin
                        fault_next = wsd_pkg::StNotWave; phase_next = PH_HALT;
                    end else begin
                        phase_next = PH_HDR; hpos_next = '0;
                    end
                end
            end
            PH_HDR: begin
                if (hpos_reg == 3'd3) id_next = tag_next;
                if (hpos_reg == 3'd7) begin
                    hpos_next = '0;
                    left_next = tag_next;
                    pad_next  = tag_next[0];
                    bpos_next = '0;
                    if (id_reg == wsd_pkg::TagFmt && tag_next >= 32'd16) begin
                        if (seen_reg[1]) begin
                            fault_next = wsd_pkg::StFmtLate; phase_next = PH_HALT;
                        end else begin
                            seen_next[0] = 1'b1; phase_next = PH_FMT;
                        end
                    end else if (id_reg == wsd_pkg::TagData && !seen_reg[1]) begin
                        seen_next[1] = 1'b1;
                        if (chan_reg == 16'd0) fault_next = wsd_pkg::StZeroChan;
                        else if (rate_reg == 32'd0) fault_next = wsd_pkg::StZeroRate;
                        else if (fmt_reg == 16'd3 && bits_reg == 16'd32) four_next = 1'b1;
                        else if (fmt_reg == 16'd1 && bits_reg == 16'd16) four_next = 1'b0;
                        else fault_next = wsd_pkg::StBadFormat;
                        if (fault_next == wsd_pkg::StOk
                            && chan_reg > 16'(wsd_pkg::MaxChannels))
                            fault_next = wsd_pkg::StManyChan;
                        if (fault_next != wsd_pkg::StOk) phase_next = PH_HALT;
                        else begin
                            bis_next = '0; ci_next = '0; phase_next = PH_DATA;
                        end
                    end else begin
                        phase_next = PH_SKIP;
                    end
                    if (phase_next != PH_HALT && tag_next == 32'd0) phase_next = PH_HDR;
                end else begin
                    hpos_next = hpos_reg + 3'd1;
                end
            end
            PH_FMT: begin
                if (bpos_reg == 5'd1) fmt_next = tag_next[31:16];
                else if (bpos_reg == 5'd3) chan_next = tag_next[31:16];
                else if (bpos_reg == 5'd7) rate_next = tag_next;
                else if (bpos_reg == 5'd15) bits_next = tag_next[31:16];
                if (bpos_reg < 5'd16) bpos_next = bpos_reg + 5'd1;
                body = 1'b1;
            end
            PH_DATA: begin
                if (bis_reg == (four_reg ? 2'd3 : 2'd1)) begin
                    bis_next = '0;
                    smp = 1'b1;
                    if (16'(ci_reg) + 16'd1 >= chan_reg) begin
                        last = 1'b1; ci_next = '0; frames_next = frames_reg + 32'd1;
                    end else begin
                        ci_next = ci_reg + 1'b1;
                    end
                end else begin
                    bis_next = bis_reg + 2'd1;
                end
                body = 1'b1;
            end
            PH_SKIP: body = 1'b1;
            PH_PAD:  begin phase_next = PH_HDR; hpos_next = '0; end
            PH_HALT: ;
            default: ;
        endcase
        if (body) begin
            left_next = left_reg - 32'd1;
            if (left_next == 32'd0) begin
                phase_next = pad_reg ? PH_PAD : PH_HDR; hpos_next = '0;
            end
        end
        if (off_reg != 32'hFFFF_FFFF) off_next = off_reg + 32'd1;

        if (off_next < 32'd12) st = wsd_pkg::StShort;
        else if (fault_next != wsd_pkg::StOk) st = fault_next;
        else if (!seen_next[1]) st = wsd_pkg::StNoData;
        else if (frames_next == 32'd0) st = wsd_pkg::StNoAudio;
        else st = wsd_pkg::StOk;

        job.smp       = smp;
        job.is_float  = four_reg;
        job.word      = tag_next;
        job.last      = last;
        job.eof       = in_eof;
        job.status    = st;
        job.rate      = rate_next;
        job.chans     = chan_next;
        job.bits      = bits_next;
        job.fmt_float = (fmt_next == 16'd3);
        job_valid     = fire && (smp || in_eof);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && in_eof)) begin
            phase_reg <= PH_RIFF; off_reg <= '0; tag_reg <= '0; left_reg <= '0;
            rate_reg <= '0; id_reg <= '0; fmt_reg <= '0; chan_reg <= '0; bits_reg <= '0;
            seen_reg <= '0; pad_reg <= 1'b0; four_reg <= 1'b0; bis_reg <= '0;
            ci_reg <= '0; frames_reg <= '0; fault_reg <= '0; hpos_reg <= '0;
            bpos_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next; off_reg <= off_next; tag_reg <= tag_next;
            left_reg <= left_next; rate_reg <= rate_next; id_reg <= id_next;
            fmt_reg <= fmt_next; chan_reg <= chan_next; bits_reg <= bits_next;
            seen_reg <= seen_next; pad_reg <= pad_next; four_reg <= four_next;
            bis_reg <= bis_next; ci_reg <= ci_next; frames_reg <= frames_next;
            fault_reg <= fault_next; hpos_reg <= hpos_next; bpos_reg <= bpos_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> (job.smp || job.eof)) else $error("empty job");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_HALT) |-> !job.smp) else $error("sample after halt");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (16'(ci_reg) < chan_reg)) else $error("channel overrun");
endmodule
`default_nettype wire

// ===== design/wsd_queue.sv =====
// Short queue between the parser and the mixer.
`default_nettype none
module wsd_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire wsd_pkg::wsd_job_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output wsd_pkg::wsd_job_t      rd_data
);
    wsd_pkg::wsd_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !rd) else $error("queue underflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 2'd1)) else $error("count slip");
endmodule
`default_nettype wire

// ===== design/wsd_mixer.sv =====
// Back part: converts samples, sums a frame, divides by channel count and forms results.
`default_nettype none
module wsd_mixer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire wsd_pkg::wsd_job_t job,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [23:0]            m_sample,
    output logic                   m_svalid,
    output logic                   m_done,
    output logic [3:0]             m_status,
    output logic [31:0]            m_rate,
    output logic [15:0]            m_chans,
    output logic [15:0]            m_bits,
    output logic                   m_float,
    output logic [31:0]            m_frames
);
    localparam int SW = wsd_pkg::SumW;
    localparam int CW = wsd_pkg::ChanW;
    typedef enum logic [1:0] {S_TAKE, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic signed [SW-1:0] sum_reg;
    logic [SW-1:0]        rem_reg, quo_reg;
    logic [CW-1:0]        cnt_reg;
    logic [$clog2(SW+1)-1:0] step_reg;
    logic                 neg_reg, emit_reg;
    wsd_pkg::wsd_job_t    hold_reg;
    logic [31:0]          frames_reg;
    logic signed [SW-1:0] acc, sq;
    logic [SW-1:0]        mag, trial;
    logic [CW:0]          dv;

    assign job_ready = (state_reg == S_TAKE) && !m_valid;
    assign acc  = sum_reg + SW'(wsd_pkg::to_fixed(job.word, job.is_float));
    assign mag  = acc[SW-1] ? SW'(-acc) : SW'(acc);
    assign dv   = {1'b0, cnt_reg} + 1'b1;
    assign trial = {rem_reg[SW-2:0], quo_reg[SW-1]};
    assign sq    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_TAKE; m_valid <= 1'b0; sum_reg <= '0; cnt_reg <= '0;
            frames_reg <= '0; emit_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_TAKE: if (job_valid && job_ready) begin
                    hold_reg <= job;
                    emit_reg <= job.smp && job.last;
                    if (job.smp && job.last) begin
                        neg_reg <= acc[SW-1]; quo_reg <= mag; rem_reg <= '0;
                        step_reg <= '0; state_reg <= S_DIV;
                        frames_reg <= frames_reg + 32'd1;
                    end else begin
                        if (job.smp) begin
                            sum_reg <= acc; cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (job.eof) state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    // One restoring step per cycle, quotient shifts into quo_reg.
                    if (trial >= SW'(dv)) begin
                        rem_reg <= trial - SW'(dv); quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial; quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == ($clog2(SW+1))'(SW - 1)) state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_valid  <= 1'b1;
                    m_svalid <= emit_reg;
                    m_sample <= emit_reg ? sq[23:0] : 24'd0;
                    m_done   <= hold_reg.eof;
                    m_status <= hold_reg.eof ? hold_reg.status : 4'd0;
                    m_rate   <= hold_reg.eof ? hold_reg.rate : 32'd0;
                    m_chans  <= hold_reg.eof ? hold_reg.chans : 16'd0;
                    m_bits   <= hold_reg.eof ? hold_reg.bits : 16'd0;
                    m_float  <= hold_reg.eof && hold_reg.fmt_float;
                    m_frames <= hold_reg.eof ? frames_reg : 32'd0;
                    if (emit_reg) begin
                        sum_reg <= '0; cnt_reg <= '0;
                    end
                    if (hold_reg.eof) begin
                        frames_reg <= '0; sum_reg <= '0; cnt_reg <= '0;
                    end
                    state_reg <= S_TAKE;
                end
                default: state_reg <= S_TAKE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_OUT))
        else $error("divider left early");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> m_valid) else $error("result not posted");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ===== design/wave_stream_decoder_downmix.sv =====
// Top level of the WAVE byte stream decoder with mono downmix.
`default_nettype none
// Channel | Dir | tdata                                  | tuser
// s_      | in  | file_byte[7:0]                         | -  (tlast = end_of_file)
// m_      | out | mono_sample, rate, chans, bits, frames  | sample_valid,done,was_float,status
// One byte request is taken per cycle while the queue has room.
// A frame end passes through the restoring divider of the mixer.
// A byte that gives no result puts no job into the queue.
// Reset is synchronous on aresetn low; the tlast request returns the parser to reset.
// Stalls on m_ fill the two-entry queue and then hold s_tready low.
module wave_stream_decoder_downmix (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // file_byte[7:0]
    input  wire logic         s_tlast,   // end_of_file
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // mono_sample[23:0], rate_out[55:24], channels_out[71:56], bits_out[87:72],
    // frames_out[119:88]
    output logic [119:0]      m_tdata,
    // sample_valid[0], done_res[1], was_float[2], status[6:3]
    output logic [6:0]        m_tuser
);
    logic              jv, jr, qv, qr;
    wsd_pkg::wsd_job_t jd, qd;
    logic [23:0] smp;
    logic [31:0] rate, frames;
    logic [15:0] ch, bits;
    logic        sv, dn, fl;
    logic [3:0]  st;

    wsd_parser u_parser (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_eof(s_tlast), .job_valid(jv), .job(jd), .job_ready(jr));
    wsd_queue u_queue (.aclk, .aresetn, .wr_valid(jv), .wr_ready(jr), .wr_data(jd),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qd));
    wsd_mixer u_mixer (.aclk, .aresetn, .job_valid(qv), .job_ready(qr), .job(qd),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_sample(smp), .m_svalid(sv),
        .m_done(dn), .m_status(st), .m_rate(rate), .m_chans(ch), .m_bits(bits),
        .m_float(fl), .m_frames(frames));

    assign m_tdata = {frames, bits, ch, rate, smp};
    assign m_tuser = {st, fl, dn, sv};
endmodule
`default_nettype wire
